/* hw/rtl/sstf_pkg.sv */
// Package for the SSTF disk request scheduler.
// Holds word types, field widths, function codes and default parameters.
// No dependencies.
package sstf_pkg;

    // Fixed field widths of the request and response words
    localparam int POS_W   = 16;
    localparam int DIST_W  = 16;
    localparam int TOTAL_W = 21;

    // Parameter defaults
    localparam int MAX_REQUESTS_DEF = 32;
    localparam int TRACK_BITS_DEF   = 16;

    // Function codes of a request word
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
    } req_word_t;

    typedef struct packed {
        logic [POS_W-1:0]   head_track;
        logic [DIST_W-1:0]  move_distance;
        logic [TOTAL_W-1:0] total_seek;
        logic               dropped;
        logic               last;
    } rsp_word_t;

    // Control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic valid;
        logic served;
    } scan_ctrl_t;

    // Status from the compare unit back to the sequencer
    typedef struct packed {
        logic found;
    } scan_stat_t;

endpackage

/* hw/rtl/sstf_store.sv */
// Request track store: one write port, one registered read port.
// Depends on nothing outside this file.
module sstf_store #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write a loaded track
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry per cycle, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/sstf_scan.sv */
// Shared distance and compare unit: keeps the nearest unserved entry of a scan.
// Depends on sstf_pkg.
module sstf_scan #(
    parameter int TRACK_BITS = 16,
    parameter int IDX_W      = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sstf_pkg::scan_ctrl_t    ctrl,
    input  logic [TRACK_BITS-1:0]   head,
    input  logic [TRACK_BITS-1:0]   entry,
    input  logic [IDX_W-1:0]        entry_idx,
    output sstf_pkg::scan_stat_t    stat,
    output logic [IDX_W-1:0]        best_idx,
    output logic [TRACK_BITS-1:0]   best_dist,
    output logic [TRACK_BITS-1:0]   best_track
);
    import sstf_pkg::*;

    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [TRACK_BITS-1:0] best_dist_reg;
    logic [TRACK_BITS-1:0] best_track_reg;
    logic [TRACK_BITS-1:0] gap;
    logic                  take;

    // Absolute gap between head and entry, strict compare keeps lowest index on ties
    always_comb
    begin
        gap  = (head >= entry) ? (head - entry) : (entry - head);
        take = ctrl.valid && !ctrl.served && (!found_reg || (gap < best_dist_reg));
    end

    // Clear at scan start, capture a better candidate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // Hold best candidate payload
    always_ff @(posedge clk)
    begin
        if (take && !ctrl.clear)
        begin
            best_idx_reg   <= entry_idx;
            best_dist_reg  <= gap;
            best_track_reg <= entry;
        end
    end

    assign stat.found = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_dist  = best_dist_reg;
    assign best_track = best_track_reg;

endmodule

/* hw/rtl/sstf_disk_request_scheduler_top.sv */
// A load word is taken only in the idle state; loads are accepted back to back.
// A run word with n > 0 stored requests gives its start word, then one served word
// per scan pass: the shared compare unit reads one store entry per cycle over
// the n entries, then a drain state and an emit state follow.
// Reset clears the request count, served bits, overflow flag and all control.
module sstf_disk_request_scheduler_top #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sstf_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sstf_pkg::rsp_word_t rsp
);
    import sstf_pkg::*;

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic                     overflow_reg;
    logic [MAX_REQUESTS-1:0]  served_reg;
    logic [TRACK_BITS-1:0]    head_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     drop_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         k_reg;
    logic                     cmp_valid_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_served_reg;
    logic                     rsp_valid_reg;
    rsp_word_t                rsp_reg;

    logic                     req_fire;
    logic                     out_free;
    logic                     emit_fire;
    logic                     emit_last;
    logic                     issue_last;
    logic                     store_wr;
    logic [CNT_W-1:0]         n_last;
    logic [TOTAL_W-1:0]       total_sum;
    logic [TRACK_BITS-1:0]    rd_track;
    scan_ctrl_t               scan_ctrl;
    scan_stat_t               scan_stat;
    logic [IDX_W-1:0]         best_idx;
    logic [TRACK_BITS-1:0]    best_dist;
    logic [TRACK_BITS-1:0]    best_track;

    // Handshake and sequencing conditions
    always_comb
    begin
        req_ready  = (state_reg == S_IDLE);
        req_fire   = req_valid && req_ready;
        out_free   = !rsp_valid_reg || rsp_ready;
        emit_fire  = ((state_reg == S_START) || (state_reg == S_EMIT)) && out_free;
        n_last     = n_reg - CNT_W'(1);
        emit_last  = (state_reg == S_EMIT) && (k_reg == n_last);
        issue_last = (CNT_W'(idx_reg) == n_last);
        store_wr   = req_fire && (req.func == FUNC_LOAD)
                     && (count_reg < CNT_W'(MAX_REQUESTS));
        total_sum  = total_reg + TOTAL_W'(best_dist);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.func == FUNC_RUN) && (count_reg != '0))
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (out_free)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Compare unit control: clear before each scan pass
    always_comb
    begin
        scan_ctrl.clear  = emit_fire && !emit_last;
        scan_ctrl.valid  = cmp_valid_reg;
        scan_ctrl.served = cmp_served_reg;
    end

    // Sequencer, store bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            served_reg     <= '0;
            head_reg       <= '0;
            total_reg      <= '0;
            drop_reg       <= 1'b0;
            n_reg          <= '0;
            idx_reg        <= '0;
            k_reg          <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            cmp_served_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_valid_reg  <= (state_reg == S_SCAN);
            cmp_idx_reg    <= idx_reg;
            cmp_served_reg <= served_reg[idx_reg];

            // Raise the output word on emit, drop it once taken
            if (emit_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // Accept load or run word
            if (req_fire)
            begin
                if (req.func == FUNC_LOAD)
                begin
                    if (store_wr)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
                else
                begin
                    head_reg     <= TRACK_BITS'(req.position);
                    total_reg    <= '0;
                    drop_reg     <= overflow_reg;
                    overflow_reg <= 1'b0;
                    n_reg        <= count_reg;
                    served_reg   <= '0;
                end
            end

            // Emit start word
            if ((state_reg == S_START) && out_free)
            begin
                rsp_reg.head_track    <= POS_W'(head_reg);
                rsp_reg.move_distance <= '0;
                rsp_reg.total_seek    <= '0;
                rsp_reg.dropped       <= drop_reg;
                rsp_reg.last          <= 1'b0;
                idx_reg               <= '0;
                k_reg                 <= '0;
            end

            // Advance scan address
            if (state_reg == S_SCAN)
            begin
                idx_reg <= issue_last ? '0 : (idx_reg + IDX_W'(1));
            end

            // Emit served word, move head, mark entry served
            if ((state_reg == S_EMIT) && out_free)
            begin
                rsp_reg.head_track    <= POS_W'(best_track);
                rsp_reg.move_distance <= DIST_W'(best_dist);
                rsp_reg.total_seek    <= total_sum;
                rsp_reg.dropped       <= drop_reg;
                rsp_reg.last          <= emit_last;
                total_reg             <= total_sum;
                head_reg              <= best_track;
                served_reg[best_idx]  <= 1'b1;
                k_reg                 <= k_reg + CNT_W'(1);
                idx_reg               <= '0;
                if (emit_last)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sstf_store #(
        .DEPTH  (MAX_REQUESTS),
        .WIDTH  (TRACK_BITS),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (TRACK_BITS'(req.position)),
        .rd_addr (idx_reg),
        .rd_data (rd_track)
    );

    sstf_scan #(
        .TRACK_BITS (TRACK_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .head       (head_reg),
        .entry      (rd_track),
        .entry_idx  (cmp_idx_reg),
        .stat       (scan_stat),
        .best_idx   (best_idx),
        .best_dist  (best_dist),
        .best_track (best_track)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REQUESTS))
        else $error("request count above capacity");

    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> scan_stat.found)
        else $error("served word without a candidate");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_last) |=> ((count_reg == '0) && (state_reg == S_IDLE)))
        else $error("store not cleared after last word");

    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg < n_reg))
        else $error("scan started with no unserved request");
`endif

endmodule
